// ----- design/iiss_pkg.sv -----
// Shared constants, codes and types for the inter-event interval statistics block.
package iiss_pkg;

  localparam int TIME_BITS  = 48;
  localparam int DELTA_BITS = 32;
  localparam int COUNT_BITS = 24;

  localparam int SUM_W  = DELTA_BITS + COUNT_BITS;      // sum and jitter accumulators
  localparam int SQ_W   = 2 * DELTA_BITS + COUNT_BITS;  // sum of squares
  localparam int NUM_W  = 2 * SUM_W;                    // variance numerator
  localparam int CNT_W  = $clog2(SUM_W + 1);

  localparam int OP_W       = 2;
  localparam int IN_DATA_W  = ((TIME_BITS + 7) / 8) * 8;
  localparam int OUT_RAW_W  = 6 * DELTA_BITS + COUNT_BITS + 1;
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;
  localparam int OUT_USER_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_EVENT = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    K_MUL  = 2'd0,
    K_DIV  = 2'd1,
    K_SQRT = 2'd2
  } kind_e;

  typedef struct packed {
    logic             start;
    kind_e            kind;
    logic [CNT_W-1:0] steps;
  } unit_req_t;

endpackage

// ----- design/iiss_unit.sv -----
// Shared bit-serial unit: shift-add multiply, restoring divide, restoring square root.
module iiss_unit
  import iiss_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  unit_req_t        req_i,
  input  logic [NUM_W-1:0] a_i,
  input  logic [SUM_W-1:0] b_i,
  output logic             done_o,
  output logic [NUM_W-1:0] prod_o,
  output logic [SUM_W-1:0] quo_o,
  output logic [SUM_W-1:0] root_o
);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  kind_e            kind_q;
  logic [NUM_W-1:0] x_q, r_q;
  logic [SUM_W-1:0] y_q, q_q;

  logic [NUM_W-1:0] tr_div, tr_sqrt, trial, op_a, op_b;
  logic             sub;
  logic [NUM_W:0]   sum;
  logic             carry;

  always_comb begin
    tr_div  = {r_q[NUM_W-2:0], x_q[SUM_W-1]};
    tr_sqrt = {r_q[NUM_W-3:0], x_q[NUM_W-1 -: 2]};
    trial   = {{(NUM_W-SUM_W-2){1'b0}}, y_q, 2'b01};
    case (kind_q)
      K_MUL: begin
        op_a = r_q;
        op_b = x_q;
        sub  = 1'b0;
      end
      K_DIV: begin
        op_a = tr_div;
        op_b = NUM_W'(y_q);
        sub  = 1'b1;
      end
      default: begin
        op_a = tr_sqrt;
        op_b = trial;
        sub  = 1'b1;
      end
    endcase
    // one adder; on subtract, carry out means no borrow
    sum   = {1'b0, op_a} + {1'b0, (sub ? ~op_b : op_b)} + (NUM_W+1)'(sub);
    carry = sum[NUM_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      kind_q <= K_MUL;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.steps;
        kind_q <= req_i.kind;
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      x_q <= a_i;
      y_q <= b_i;
      r_q <= '0;
      q_q <= '0;
    end else if (busy_q) begin
      case (kind_q)
        K_MUL: begin
          if (y_q[0]) r_q <= sum[NUM_W-1:0];
          x_q <= {x_q[NUM_W-2:0], 1'b0};
          y_q <= {1'b0, y_q[SUM_W-1:1]};
        end
        K_DIV: begin
          r_q <= carry ? sum[NUM_W-1:0] : tr_div;
          q_q <= {q_q[SUM_W-2:0], carry};
          x_q <= {x_q[NUM_W-2:0], 1'b0};
        end
        default: begin
          r_q <= carry ? sum[NUM_W-1:0] : tr_sqrt;
          y_q <= {y_q[SUM_W-2:0], carry};
          x_q <= {x_q[NUM_W-3:0], 2'b00};
        end
      endcase
    end
  end

  assign done_o = done_q;
  assign prod_o = r_q;
  assign quo_o  = q_q;
  assign root_o = y_q;

endmodule

// ----- design/inter_event_interval_statistics_top.sv -----
// Top level: event/command intake, statistics registers and the sequencer around the shared unit.
//
// Channel  Dir  Handshake               Payload
// s_axis   in   tvalid/tready           tuser: op; tdata: event_time
// m_axis   out  tvalid/tready           tuser: accepted, delta_valid; tdata: statistics
//
// With no interval recorded yet, a transaction goes from S_STAT straight to S_OUT.
// Otherwise the statistics pass runs its jobs on the bit-serial unit in order: sum squared,
// n times sum of squares, square root of their difference, then divides for stddev, mean and
// jitter (no jitter divide at one interval). An event that adds an interval first updates the
// stats and squares the new interval on the unit; one with the count full sets overflow only.
// tready is low from acceptance until the result is loaded into the output register; that
// register then waits for m_axis_tready without holding up the next transaction, and a full
// register holds the sequencer in its last state. Reset clears measuring and all stats.
module inter_event_interval_statistics_top
  import iiss_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [47:0] event_time
  input  logic [OP_W-1:0]       s_axis_tuser,   // [1:0] op
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // delta_ns, interval_count, min_ns, max_ns, mean_ns, jitter_ns, stddev_ns, overflow
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic [OUT_USER_W-1:0] m_axis_tuser    // [0] accepted, [1] delta_valid
);

  typedef enum logic [4:0] {
    S_IDLE, S_DELTA, S_ABS, S_UPD, S_SQ_GO, S_SQ_WT, S_STAT,
    S_B_GO, S_B_WT, S_A_GO, S_A_WT, S_RT_GO, S_RT_WT,
    S_SD_GO, S_SD_WT, S_MN_GO, S_MN_WT, S_JT_GO, S_JT_WT, S_OUT
  } state_e;

  localparam logic [DELTA_BITS-1:0] DELTA_MAX = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  state_e state_q;
  logic   measuring_q, have_last_q, ovf_q;
  logic [TIME_BITS-1:0]  last_q, ts_q;
  logic [DELTA_BITS-1:0] prev_q, min_q, max_q, delta_q, absd_q;
  logic [COUNT_BITS-1:0] count_q;
  logic [SUM_W-1:0]      sum_q, jit_sum_q, root_q;
  logic [SQ_W-1:0]       sq_q;
  logic [NUM_W-1:0]      tmp_q;
  logic [DELTA_BITS-1:0] mean_q, jit_q, sd_q;
  logic                  acc_q, dv_q, m_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic [OUT_USER_W-1:0] out_user_q;

  unit_req_t        req;
  logic [NUM_W-1:0] ua;
  logic [SUM_W-1:0] ub;
  logic             u_done;
  logic [NUM_W-1:0] u_prod;
  logic [SUM_W-1:0] u_quo, u_root;

  logic [TIME_BITS-1:0]  diff;
  logic [SUM_W-1:0]      n_ext;
  logic                  in_hs;
  logic                  stats_on;

  assign in_hs    = s_axis_tvalid && s_axis_tready;
  assign diff     = ts_q - last_q;
  assign n_ext    = SUM_W'(count_q);
  assign stats_on = (count_q != '0);

  always_comb begin
    req   = '{start: 1'b0, kind: K_MUL, steps: CNT_W'(SUM_W)};
    ua    = '0;
    ub    = '0;
    case (state_q)
      S_SQ_GO: begin
        req = '{start: 1'b1, kind: K_MUL, steps: CNT_W'(DELTA_BITS)};
        ua  = NUM_W'(delta_q);
        ub  = SUM_W'(delta_q);
      end
      S_B_GO: begin
        req = '{start: 1'b1, kind: K_MUL, steps: CNT_W'(SUM_W)};
        ua  = NUM_W'(sum_q);
        ub  = sum_q;
      end
      S_A_GO: begin
        req = '{start: 1'b1, kind: K_MUL, steps: CNT_W'(COUNT_BITS)};
        ua  = NUM_W'(sq_q);
        ub  = n_ext;
      end
      S_RT_GO: begin
        req = '{start: 1'b1, kind: K_SQRT, steps: CNT_W'(SUM_W)};
        ua  = tmp_q;
      end
      S_SD_GO: begin
        req = '{start: 1'b1, kind: K_DIV, steps: CNT_W'(SUM_W)};
        ua  = NUM_W'(root_q);
        ub  = n_ext;
      end
      S_MN_GO: begin
        req = '{start: 1'b1, kind: K_DIV, steps: CNT_W'(SUM_W)};
        ua  = NUM_W'(sum_q);
        ub  = n_ext;
      end
      S_JT_GO: begin
        req = '{start: 1'b1, kind: K_DIV, steps: CNT_W'(SUM_W)};
        ua  = NUM_W'(jit_sum_q);
        ub  = n_ext - SUM_W'(1);
      end
      default: ;
    endcase
  end

  iiss_unit u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .a_i    (ua),
    .b_i    (ub),
    .done_o (u_done),
    .prod_o (u_prod),
    .quo_o  (u_quo),
    .root_o (u_root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      measuring_q <= 1'b0;
      have_last_q <= 1'b0;
      last_q      <= '0;
      prev_q      <= '0;
      count_q     <= '0;
      sum_q       <= '0;
      min_q       <= '1;
      max_q       <= '0;
      jit_sum_q   <= '0;
      sq_q        <= '0;
      ovf_q       <= 1'b0;
      m_valid_q   <= 1'b0;
    end else begin
      if (state_q == S_OUT && (!m_valid_q || m_axis_tready)) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_hs) begin
            state_q <= S_STAT;
            if (s_axis_tuser == OP_START || s_axis_tuser == OP_CLEAR) begin
              have_last_q <= 1'b0;
              last_q      <= '0;
              prev_q      <= '0;
              count_q     <= '0;
              sum_q       <= '0;
              min_q       <= '1;
              max_q       <= '0;
              jit_sum_q   <= '0;
              sq_q        <= '0;
              ovf_q       <= 1'b0;
            end
            if (s_axis_tuser == OP_START) measuring_q <= 1'b1;
            if (s_axis_tuser == OP_STOP)  measuring_q <= 1'b0;
            if (s_axis_tuser == OP_EVENT && measuring_q) begin
              if (have_last_q) begin
                state_q <= S_DELTA;
              end else begin
                have_last_q <= 1'b1;
                last_q      <= s_axis_tdata[TIME_BITS-1:0];
              end
            end
          end
        end
        S_DELTA: begin
          last_q <= ts_q;
          if (count_q == COUNT_MAX) begin
            ovf_q   <= 1'b1;
            state_q <= S_STAT;
          end else begin
            state_q <= S_ABS;
          end
        end
        S_ABS: state_q <= S_UPD;
        S_UPD: begin
          if (count_q != '0) jit_sum_q <= jit_sum_q + SUM_W'(absd_q);
          count_q <= count_q + COUNT_BITS'(1);
          sum_q   <= sum_q + SUM_W'(delta_q);
          if (delta_q < min_q) min_q <= delta_q;
          if (delta_q > max_q) max_q <= delta_q;
          prev_q  <= delta_q;
          state_q <= S_SQ_GO;
        end
        S_SQ_GO: state_q <= S_SQ_WT;
        S_SQ_WT: begin
          if (u_done) begin
            sq_q    <= sq_q + u_prod[SQ_W-1:0];
            state_q <= S_STAT;
          end
        end
        S_STAT:  state_q <= stats_on ? S_B_GO : S_OUT;
        S_B_GO:  state_q <= S_B_WT;
        S_B_WT:  if (u_done) state_q <= S_A_GO;
        S_A_GO:  state_q <= S_A_WT;
        S_A_WT:  if (u_done) state_q <= S_RT_GO;
        S_RT_GO: state_q <= S_RT_WT;
        S_RT_WT: if (u_done) state_q <= S_SD_GO;
        S_SD_GO: state_q <= S_SD_WT;
        S_SD_WT: if (u_done) state_q <= S_MN_GO;
        S_MN_GO: state_q <= S_MN_WT;
        S_MN_WT: if (u_done) state_q <= (count_q > COUNT_BITS'(1)) ? S_JT_GO : S_OUT;
        S_JT_GO: state_q <= S_JT_WT;
        S_JT_WT: if (u_done) state_q <= S_OUT;
        S_OUT: begin
          if (!m_valid_q || m_axis_tready) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers without reset
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_hs) begin
          ts_q    <= s_axis_tdata[TIME_BITS-1:0];
          acc_q   <= (s_axis_tuser == OP_EVENT) && measuring_q;
          dv_q    <= 1'b0;
          delta_q <= '0;
        end
      end
      S_DELTA: begin
        dv_q    <= 1'b1;
        delta_q <= (diff > TIME_BITS'(DELTA_MAX)) ? DELTA_MAX : diff[DELTA_BITS-1:0];
      end
      S_ABS:   absd_q <= (delta_q > prev_q) ? delta_q - prev_q : prev_q - delta_q;
      S_STAT: begin
        mean_q <= '0;
        jit_q  <= '0;
        sd_q   <= '0;
      end
      S_B_WT:  if (u_done) tmp_q <= u_prod;
      S_A_WT:  if (u_done) tmp_q <= u_prod - tmp_q;
      S_RT_WT: if (u_done) root_q <= u_root;
      S_SD_WT: if (u_done) sd_q <= u_quo[DELTA_BITS-1:0];
      S_MN_WT: if (u_done) mean_q <= u_quo[DELTA_BITS-1:0];
      S_JT_WT: if (u_done) jit_q <= u_quo[DELTA_BITS-1:0];
      S_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          out_user_q <= {dv_q, acc_q};
          out_data_q <= OUT_DATA_W'({ovf_q, sd_q, jit_q, mean_q,
                                     (stats_on ? max_q : {DELTA_BITS{1'b0}}),
                                     (stats_on ? min_q : {DELTA_BITS{1'b0}}),
                                     count_q, delta_q});
        end
      end
      default: ;
    endcase
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

// ----- design/iiss_checker.sv -----
// Port-level checker for the interval statistics block, bound to the top level.
module iiss_checker
  import iiss_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic [OUT_USER_W-1:0] m_axis_tuser
);

  // one transaction at a time: intake closes after each accept
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while previous transaction in progress");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_interval_needs_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[1] && !m_axis_tuser[0]))
    else $error("interval reported without accepted event");

  a_no_interval_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tdata[DELTA_BITS-1:0] == '0)
    else $error("delta nonzero without a new interval");

endmodule

bind inter_event_interval_statistics_top iiss_checker u_iiss_checker (.*);

// ----- verif/tb_inter_event_interval_statistics_top.sv -----
// Self-checking testbench for the inter-event interval statistics top level.
module tb_inter_event_interval_statistics_top;
  import iiss_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    bit        accepted;
    bit        dvalid;
    bit [31:0] delta;
    bit [23:0] count;
    bit [31:0] min_ns;
    bit [31:0] max_ns;
    bit [31:0] mean;
    bit [31:0] jitter;
    bit [31:0] stddev;
    bit        ovf;
  } stats_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [OP_W-1:0]       s_axis_tuser = OP_EVENT;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [OUT_USER_W-1:0] m_axis_tuser;

  inter_event_interval_statistics_top dut (.*);

  // predictor state
  bit         run_on, have_ref;
  bit [47:0]  ref_time;
  bit [31:0]  last_ival, min_ival, max_ival;
  bit [23:0]  ival_count;
  bit [63:0]  ival_sum, jit_sum;
  bit [127:0] sq_sum;
  bit         sat_flag;

  stats_t     stats_q[$];
  int         n_items, n_results, n_errors, n_intervals;
  int         idle_pct, stall_pct;
  bit [47:0]  clock_ts;

  initial forever #5 clk_i = ~clk_i;

  initial begin
    #50ms;
    $display("timeout");
    $display("tb_inter_event_interval_statistics_top: done, errors");
    $finish;
  end

  function automatic void wipe_stats();
    have_ref = 0; ref_time = '0; last_ival = '0; ival_count = '0; ival_sum = '0;
    min_ival = '1; max_ival = '0; jit_sum = '0; sq_sum = '0; sat_flag = 0;
  endfunction

  function automatic bit [63:0] root_floor(bit [127:0] x);
    bit [63:0]  r, t;
    bit [127:0] sq;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      t = r | (64'd1 << b);
      sq = {64'd0, t} * {64'd0, t};
      if (sq <= x) r = t;
    end
    return r;
  endfunction

  function automatic stats_t predict_stats(op_e op, bit [47:0] ts);
    stats_t     e;
    bit [47:0]  d48;
    bit [31:0]  d;
    bit [127:0] a, b;
    e = '{default: 0};
    case (op)
      OP_START: begin
        wipe_stats();
        run_on = 1;
      end
      OP_STOP: run_on = 0;
      OP_CLEAR: wipe_stats();
      default: if (run_on) begin
        e.accepted = 1;
        if (have_ref) begin
          d48 = ts - ref_time;
          d = (d48 > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : d48[31:0];
          e.dvalid = 1;
          e.delta = d;
          if (ival_count == 24'hFF_FFFF) begin
            sat_flag = 1;
          end else begin
            if (ival_count != 0)
              jit_sum += 64'((d > last_ival) ? d - last_ival : last_ival - d);
            ival_count++;
            ival_sum += 64'(d);
            if (d < min_ival) min_ival = d;
            if (d > max_ival) max_ival = d;
            sq_sum += {96'd0, d} * {96'd0, d};
            last_ival = d;
          end
        end
        ref_time = ts;
        have_ref = 1;
      end
    endcase
    e.count = ival_count;
    if (ival_count != 0) begin
      e.min_ns = min_ival;
      e.max_ns = max_ival;
      e.mean = 32'(ival_sum / ival_count);
      if (ival_count > 1) e.jitter = 32'(jit_sum / (ival_count - 1));
      a = sq_sum * {104'd0, ival_count};
      b = {64'd0, ival_sum} * {64'd0, ival_sum};
      if (b <= a) e.stddev = 32'(root_floor(a - b) / ival_count);
    end
    e.ovf = sat_flag;
    return e;
  endfunction

  // one transaction on the input side; idles at random per idle_pct, else the caller sends again right after
  task automatic send_item(op_e op, bit [47:0] ts);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= ts;
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    stats_q.push_back(predict_stats(op, ts));
    n_items++;
    if (op == OP_EVENT && stats_q[$].dvalid) n_intervals++;
    if ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  endtask

  task automatic pause_sender();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    pause_sender();
    while (stats_q.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  // receiver stall
  always @(posedge clk_i) m_axis_tready <= ($urandom_range(99) >= stall_pct);

  // result checker: handshake is fixed at negedge, completes on the next rising edge
  always @(negedge clk_i) begin
    stats_t e, g;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      g.accepted = m_axis_tuser[0];
      g.dvalid   = m_axis_tuser[1];
      g.delta    = m_axis_tdata[31:0];
      g.count    = m_axis_tdata[55:32];
      g.min_ns   = m_axis_tdata[87:56];
      g.max_ns   = m_axis_tdata[119:88];
      g.mean     = m_axis_tdata[151:120];
      g.jitter   = m_axis_tdata[183:152];
      g.stddev   = m_axis_tdata[215:184];
      g.ovf      = m_axis_tdata[216];
      if (stats_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected transaction: %p", g);
      end else begin
        e = stats_q.pop_front();
        if (e != g) begin
          n_errors++;
          if (n_errors <= 10) $display("mismatch at result %0d\n  exp %p\n  got %p",
                                       n_results, e, g);
        end
      end
    end
  end

  task automatic test_directed();
    idle_pct = 0; stall_pct = 0;
    send_item(OP_EVENT, 48'h1234);          // ignored while stopped
    send_item(OP_START, 48'hFFFF_FFFF_FFFF);
    send_item(OP_EVENT, 48'h0);             // first event sets reference only
    send_item(OP_EVENT, 48'h0);             // zero interval
    send_item(OP_EVENT, 48'h64);
    send_item(OP_EVENT, 48'h3E8);
    send_item(OP_EVENT, 48'hFFFF_FFFF_FFFF); // saturates
    send_item(OP_EVENT, 48'h10);            // wraps through rollover
    send_item(OP_EVENT, 48'h1_0000_000F);   // exactly max delta
    send_item(OP_EVENT, 48'h5);             // backwards
    send_item(OP_STOP, 48'h0);
    send_item(OP_EVENT, 48'hAAAA_AAAA_AAAA);
    send_item(OP_EVENT, 48'h5555_5555_5555);
    send_item(OP_START, 48'h0);
    send_item(OP_EVENT, 48'h8000_0000_0000);
    send_item(OP_EVENT, 48'h8000_0000_0001);
    send_item(OP_CLEAR, 48'h0);             // keeps measuring
    send_item(OP_EVENT, 48'h100);
    send_item(OP_EVENT, 48'h200);
    send_item(OP_EVENT, 48'h300);
    send_item(OP_EVENT, 48'h500);
    send_item(OP_STOP, 48'h0);
    send_item(OP_CLEAR, 48'h0);
    wait_drained();
  endtask

  task automatic test_random(int n, int idle, int stall);
    int        k;
    idle_pct = idle; stall_pct = stall;
    send_item(OP_START, 48'({$urandom, $urandom}));
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 4) begin
        send_item(op_e'($urandom_range(1, 3)), 48'({$urandom, $urandom}));
        if (!run_on && $urandom_range(1)) send_item(OP_START, '0);
      end else begin
        k = $urandom_range(99);
        if (k < 70)      clock_ts += 48'($urandom_range(1, 5000));
        else if (k < 80) clock_ts += 48'd0;
        else if (k < 88) clock_ts += 48'($urandom);
        else if (k < 94) clock_ts -= 48'($urandom_range(1, 100000));
        else             clock_ts = 48'({$urandom, $urandom});
        send_item(OP_EVENT, clock_ts);
      end
    end
    wait_drained();
  endtask

  initial begin
    wipe_stats();
    run_on = 0;
    clock_ts = 48'({$urandom, $urandom});
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_directed();
    test_random(130, 0, 0);
    test_random(125, 51, 0);
    test_random(125, 0, 51);
    test_random(125, 20, 20);
    $display("covered %0d input transactions, %0d results, %0d intervals over four idle/stall mixes",
             n_items, n_results, n_intervals);
    $display("mismatches: %0d", n_errors);
    if (n_errors == 0) begin
      $display("tb_inter_event_interval_statistics_top: done, clean");
    end else begin
      $display("tb_inter_event_interval_statistics_top: done, errors");
    end
    $finish;
  end

endmodule

// ----- inter_event_interval_statistics_top.f -----
design/iiss_pkg.sv
design/iiss_unit.sv
design/inter_event_interval_statistics_top.sv
design/iiss_checker.sv
verif/tb_inter_event_interval_statistics_top.sv
